[hdl/aabb_ci_pkg.sv]
package aabb_ci_pkg;

   localparam int unsigned COORD_WIDTH = 32;
   localparam int unsigned NUM_AXES    = 3;
   localparam int unsigned NUM_STAGES  = 4;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [COORD_WIDTH:0]   wide_type;
   typedef logic        [COORD_WIDTH-1:0] depth_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_code_type;

   // per-stage load enables
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } adv_type;

   typedef struct packed {
      logic      hit;
      wide_type  pen;
      logic      neg;
      coord_type center;
      coord_type low;
      coord_type high;
   } axis_res_type;

   typedef struct packed {
      logic          overlapping;
      axis_code_type normal_axis;
      logic          normal_negative;
      depth_type     depth;
      coord_type     contact_x;
      coord_type     contact_y;
      coord_type     contact_z;
   } result_type;

endpackage

[hdl/aabb_ci_if.sv]
interface aabb_ci_req_if;
   logic                  valid;
   logic                  ready;
   aabb_ci_pkg::coord_type a_low_x;
   aabb_ci_pkg::coord_type a_low_y;
   aabb_ci_pkg::coord_type a_low_z;
   aabb_ci_pkg::coord_type a_high_x;
   aabb_ci_pkg::coord_type a_high_y;
   aabb_ci_pkg::coord_type a_high_z;
   aabb_ci_pkg::coord_type b_low_x;
   aabb_ci_pkg::coord_type b_low_y;
   aabb_ci_pkg::coord_type b_low_z;
   aabb_ci_pkg::coord_type b_high_x;
   aabb_ci_pkg::coord_type b_high_y;
   aabb_ci_pkg::coord_type b_high_z;

   modport source (
      output valid, a_low_x, a_low_y, a_low_z, a_high_x, a_high_y, a_high_z,
             b_low_x, b_low_y, b_low_z, b_high_x, b_high_y, b_high_z,
      input  ready
   );
   modport sink (
      input  valid, a_low_x, a_low_y, a_low_z, a_high_x, a_high_y, a_high_z,
             b_low_x, b_low_y, b_low_z, b_high_x, b_high_y, b_high_z,
      output ready
   );
endinterface

interface aabb_ci_rsp_if;
   logic                   valid;
   logic                   ready;
   logic                   overlapping;
   logic [1:0]             normal_axis;
   logic                   normal_negative;
   aabb_ci_pkg::depth_type depth;
   aabb_ci_pkg::coord_type contact_x;
   aabb_ci_pkg::coord_type contact_y;
   aabb_ci_pkg::coord_type contact_z;

   modport source (
      output valid, overlapping, normal_axis, normal_negative, depth,
             contact_x, contact_y, contact_z,
      input  ready
   );
   modport sink (
      input  valid, overlapping, normal_axis, normal_negative, depth,
             contact_x, contact_y, contact_z,
      output ready
   );
endinterface

[hdl/aabb_ci_axis.sv]
module aabb_ci_axis (
   input  logic                      clock,
   input  aabb_ci_pkg::adv_type      adv,
   input  aabb_ci_pkg::coord_type    a_low,
   input  aabb_ci_pkg::coord_type    a_high,
   input  aabb_ci_pkg::coord_type    b_low,
   input  aabb_ci_pkg::coord_type    b_high,
   output aabb_ci_pkg::axis_res_type res
);

   logic                      hit_ff, hit_in;
   aabb_ci_pkg::coord_type    up_ff, up_in;
   aabb_ci_pkg::coord_type    dn_ff, dn_in;
   aabb_ci_pkg::coord_type    alo_ff, ahi_ff;
   aabb_ci_pkg::wide_type     sa_ff, sa_in;
   aabb_ci_pkg::wide_type     sb_ff, sb_in;
   aabb_ci_pkg::axis_res_type res_ff, res_in;

   // stage 1: overlap test, min/max, center sums
   always_comb begin
      hit_in = (a_high > b_low) && (a_low < b_high);
      up_in  = (a_high < b_high) ? a_high : b_high;
      dn_in  = (a_low > b_low) ? a_low : b_low;
      sa_in  = aabb_ci_pkg::wide_type'(a_low) + aabb_ci_pkg::wide_type'(a_high);
      sb_in  = aabb_ci_pkg::wide_type'(b_low) + aabb_ci_pkg::wide_type'(b_high);
   end

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         hit_ff <= hit_in;
         up_ff  <= up_in;
         dn_ff  <= dn_in;
         sa_ff  <= sa_in;
         sb_ff  <= sb_in;
         alo_ff <= a_low;
         ahi_ff <= a_high;
      end
   end

   // stage 2: overlap width, normal sign, floor center
   always_comb begin
      res_in.hit    = hit_ff;
      res_in.pen    = aabb_ci_pkg::wide_type'(up_ff) - aabb_ci_pkg::wide_type'(dn_ff);
      res_in.neg    = sb_ff < sa_ff;
      res_in.center = aabb_ci_pkg::coord_type'(sa_ff[aabb_ci_pkg::COORD_WIDTH:1]);
      res_in.low    = alo_ff;
      res_in.high   = ahi_ff;
   end

   always_ff @(posedge clock) begin
      if (adv.s2) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

[hdl/aabb_ci_resolve.sv]
module aabb_ci_resolve (
   input  logic                      clock,
   input  aabb_ci_pkg::adv_type      adv,
   input  aabb_ci_pkg::axis_res_type ax [aabb_ci_pkg::NUM_AXES],
   output aabb_ci_pkg::result_type   res
);

   logic                       hit_ff, hit_in;
   aabb_ci_pkg::axis_code_type sel_ff, sel_in;
   logic                       neg_ff, neg_in;
   aabb_ci_pkg::depth_type     depth_ff, depth_in;
   aabb_ci_pkg::coord_type     base_ff, base_in;
   aabb_ci_pkg::coord_type     center_ff [aabb_ci_pkg::NUM_AXES];
   aabb_ci_pkg::result_type    res_ff, res_in;

   // stage 3: least penetration axis, x before y before z on ties
   always_comb begin
      aabb_ci_pkg::wide_type     best;
      aabb_ci_pkg::axis_res_type pick;
      hit_in = 1'b1;
      for (int i = 0; i < aabb_ci_pkg::NUM_AXES; i++) begin
         hit_in = hit_in & ax[i].hit;
      end
      sel_in = aabb_ci_pkg::AXIS_X;
      best   = ax[0].pen;
      if (ax[1].pen < best) begin
         sel_in = aabb_ci_pkg::AXIS_Y;
         best   = ax[1].pen;
      end
      if (ax[2].pen < best) begin
         sel_in = aabb_ci_pkg::AXIS_Z;
      end
      case (sel_in)
         aabb_ci_pkg::AXIS_X: pick = ax[0];
         aabb_ci_pkg::AXIS_Y: pick = ax[1];
         aabb_ci_pkg::AXIS_Z: pick = ax[2];
         default:             pick = ax[0];
      endcase
      depth_in = pick.pen[aabb_ci_pkg::COORD_WIDTH-1:0];
      neg_in   = pick.neg;
      base_in  = pick.neg ? pick.low : pick.high;
   end

   always_ff @(posedge clock) begin
      if (adv.s3) begin
         hit_ff   <= hit_in;
         sel_ff   <= sel_in;
         neg_ff   <= neg_in;
         depth_ff <= depth_in;
         base_ff  <= base_in;
         for (int i = 0; i < aabb_ci_pkg::NUM_AXES; i++) begin
            center_ff[i] <= ax[i].center;
         end
      end
   end

   // stage 4: face minus depth on the normal axis (plus depth for a negative normal), center elsewhere
   always_comb begin
      aabb_ci_pkg::coord_type face;
      aabb_ci_pkg::coord_type pt [aabb_ci_pkg::NUM_AXES];
      face = neg_ff ? base_ff + aabb_ci_pkg::coord_type'(depth_ff)
                    : base_ff - aabb_ci_pkg::coord_type'(depth_ff);
      for (int i = 0; i < aabb_ci_pkg::NUM_AXES; i++) begin
         pt[i] = (sel_ff == aabb_ci_pkg::axis_code_type'(i)) ? face : center_ff[i];
      end
      if (hit_ff) begin
         res_in.overlapping     = 1'b1;
         res_in.normal_axis     = sel_ff;
         res_in.normal_negative = neg_ff;
         res_in.depth           = depth_ff;
         res_in.contact_x       = pt[0];
         res_in.contact_y       = pt[1];
         res_in.contact_z       = pt[2];
      end else begin
         res_in.overlapping     = 1'b0;
         res_in.normal_axis     = aabb_ci_pkg::AXIS_X;
         res_in.normal_negative = 1'b0;
         res_in.depth           = '0;
         res_in.contact_x       = '0;
         res_in.contact_y       = '0;
         res_in.contact_z       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s4) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

[hdl/aabb_contact_info.sv]
// Box pair contact engine. Each req word carries two axis-aligned boxes in
// signed Q16.16; each rsp word reports strict overlap, the least-penetration
// axis (ties go x, y, z), the normal sign, the depth and the contact point,
// or all zeros when the boxes do not overlap. One word in, one word out. The
// datapath is four register stages with the last one as the output register,
// and a new word is taken every cycle while req ready is high. Back-pressure on
// rsp stalls only the stages that hold words; empty stages keep filling, so req
// ready drops only when all four stages are occupied and rsp is not ready.
module aabb_contact_info (
   input  logic                 clock,
   input  logic                 reset,
   aabb_ci_req_if.sink          req_in,
   aabb_ci_rsp_if.source        rsp_out
);

   localparam int unsigned LAST = aabb_ci_pkg::NUM_STAGES - 1;

   logic [aabb_ci_pkg::NUM_STAGES-1:0] v_ff, v_in, go;
   aabb_ci_pkg::adv_type               adv;
   aabb_ci_pkg::axis_res_type          ax [aabb_ci_pkg::NUM_AXES];
   aabb_ci_pkg::result_type            res;

   always_comb begin
      go[LAST] = !v_ff[LAST] || rsp_out.ready;
      for (int k = LAST - 1; k >= 0; k--) begin
         go[k] = !v_ff[k] || go[k+1];
      end
      v_in[0] = go[0] ? req_in.valid : v_ff[0];
      for (int k = 1; k <= LAST; k++) begin
         v_in[k] = go[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign adv.s1 = go[0];
   assign adv.s2 = go[1];
   assign adv.s3 = go[2];
   assign adv.s4 = go[3];

   aabb_ci_axis u_axis_x (
      .clock  (clock),
      .adv    (adv),
      .a_low  (req_in.a_low_x),
      .a_high (req_in.a_high_x),
      .b_low  (req_in.b_low_x),
      .b_high (req_in.b_high_x),
      .res    (ax[0])
   );

   aabb_ci_axis u_axis_y (
      .clock  (clock),
      .adv    (adv),
      .a_low  (req_in.a_low_y),
      .a_high (req_in.a_high_y),
      .b_low  (req_in.b_low_y),
      .b_high (req_in.b_high_y),
      .res    (ax[1])
   );

   aabb_ci_axis u_axis_z (
      .clock  (clock),
      .adv    (adv),
      .a_low  (req_in.a_low_z),
      .a_high (req_in.a_high_z),
      .b_low  (req_in.b_low_z),
      .b_high (req_in.b_high_z),
      .res    (ax[2])
   );

   aabb_ci_resolve u_resolve (
      .clock (clock),
      .adv   (adv),
      .ax    (ax),
      .res   (res)
   );

   assign req_in.ready            = go[0];
   assign rsp_out.valid           = v_ff[LAST];
   assign rsp_out.overlapping     = res.overlapping;
   assign rsp_out.normal_axis     = res.normal_axis;
   assign rsp_out.normal_negative = res.normal_negative;
   assign rsp_out.depth           = res.depth;
   assign rsp_out.contact_x       = res.contact_x;
   assign rsp_out.contact_y       = res.contact_y;
   assign rsp_out.contact_z       = res.contact_z;

   // req stalls only with a full pipe
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_in.ready |-> (&v_ff))
      else $error("req stalled with an empty stage");

   // a miss reports all zeros
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_out.valid && !rsp_out.overlapping |->
         rsp_out.depth == '0 && rsp_out.contact_x == '0 &&
         rsp_out.contact_y == '0 && rsp_out.contact_z == '0 &&
         !rsp_out.normal_negative && rsp_out.normal_axis == aabb_ci_pkg::AXIS_X)
      else $error("non-overlap word with nonzero fields");

   // last word taken with nothing behind it leaves rsp empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      v_ff[LAST] && rsp_out.ready && !v_ff[LAST-1] |=> !rsp_out.valid)
      else $error("rsp word repeated after drain");

endmodule
